// File: rtl/core/tt_pkg.sv
// Shared types and constants of the transposition table core.
`timescale 1ns / 1ps

package tt_pkg;

    localparam int KEY_W   = 64;
    localparam int DEPTH_W = 8;
    localparam int SCORE_W = 16;
    localparam int DS_W    = DEPTH_W + SCORE_W;

    typedef logic [1:0] op_t;

    localparam op_t OP_LOOKUP    = 2'd0;
    localparam op_t OP_INSERT    = 2'd1;
    localparam op_t OP_CLEAR_ONE = 2'd2;
    localparam op_t OP_CLEAR_ALL = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;    // latch the accepted input item
        logic mem_read;   // read the slot of the latched key
        logic mem_write;  // write the slot of the latched key
        logic clr_step;   // clear one valid mark and advance the sweep counter
        logic sweep_all;  // sweep covers both tables
        logic out_load;   // load the output register
    } tt_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        op_t  op;
        logic sweep_last;
    } tt_stat_t;

endpackage

// File: rtl/core/tt_ctrl.sv
// Controller state machine of the transposition table core.
`timescale 1ns / 1ps

module tt_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    output logic             m_tvalid,
    input  logic             m_tready,
    input  tt_pkg::tt_stat_t stat,
    output tt_pkg::tt_cmd_t  cmd
);

    typedef enum logic [4:0] {
        ST_INIT   = 5'b00001,
        ST_IDLE   = 5'b00010,
        ST_EXEC   = 5'b00100,
        ST_CLEAR  = 5'b01000,
        ST_RESULT = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_INIT;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        cmd          = '0;
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_tready;
        s_tready     = 1'b0;
        unique case (state_reg)
            ST_INIT: begin
                // After reset every valid mark is swept to zero.
                cmd.clr_step  = 1'b1;
                cmd.sweep_all = 1'b1;
                if (stat.sweep_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                unique case (stat.op) inside
                    tt_pkg::OP_LOOKUP: begin
                        cmd.mem_read = 1'b1;
                        state_next   = ST_RESULT;
                    end
                    tt_pkg::OP_INSERT: begin
                        cmd.mem_write = 1'b1;
                        state_next    = ST_RESULT;
                    end
                    tt_pkg::OP_CLEAR_ONE, tt_pkg::OP_CLEAR_ALL: begin
                        state_next = ST_CLEAR;
                    end
                endcase
            end
            ST_CLEAR: begin
                cmd.clr_step  = 1'b1;
                cmd.sweep_all = (stat.op == tt_pkg::OP_CLEAR_ALL);
                if (stat.sweep_last) begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (!m_valid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_INIT;
            end
        endcase
    end

    assign m_tvalid = m_valid_reg;

endmodule

// File: rtl/core/tt_datapath.sv
// Datapath of the transposition table core: slot memories, sweep counter, result register.
`timescale 1ns / 1ps

module tt_datapath #(
    parameter int TABLE_ENTRIES = 4096
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  tt_pkg::op_t                 in_op,
    input  logic                        in_player,
    input  logic [tt_pkg::KEY_W-1:0]    in_key,
    input  logic [tt_pkg::DEPTH_W-1:0]  in_depth,
    input  logic [tt_pkg::SCORE_W-1:0]  in_score,
    input  tt_pkg::tt_cmd_t             cmd,
    output tt_pkg::tt_stat_t            stat,
    output logic                        out_hit,
    output logic [tt_pkg::SCORE_W-1:0]  out_score
);

    localparam int AW    = $clog2(TABLE_ENTRIES);
    localparam int SLOTS = 2 * TABLE_ENTRIES;

    // Latched input item.
    tt_pkg::op_t                op_reg;
    logic                       player_reg;
    logic [tt_pkg::KEY_W-1:0]   key_reg;
    logic [tt_pkg::DEPTH_W-1:0] depth_reg;
    logic [tt_pkg::SCORE_W-1:0] score_reg;

    // Slot memories; the first player's table fills the lower half.
    logic                      valid_mem [SLOTS];
    logic [tt_pkg::KEY_W-1:0]  key_mem   [SLOTS];
    logic [tt_pkg::DS_W-1:0]   ds_mem    [SLOTS];

    logic                      rd_valid_reg;
    logic [tt_pkg::KEY_W-1:0]  rd_key_reg;
    logic [tt_pkg::DS_W-1:0]   rd_ds_reg;

    logic [AW:0] cnt_reg;
    logic [AW:0] slot_addr;
    logic [AW:0] clr_addr;
    logic [AW:0] vld_addr;
    logic        vld_wen;
    logic        vld_wdata;
    logic        lookup_hit;

    logic                       hit_reg;
    logic [tt_pkg::SCORE_W-1:0] hit_score_reg;

    assign slot_addr = {player_reg, key_reg[AW-1:0]};
    assign clr_addr  = cmd.sweep_all ? cnt_reg : {player_reg, cnt_reg[AW-1:0]};
    assign vld_addr  = cmd.clr_step ? clr_addr : slot_addr;
    assign vld_wen   = cmd.clr_step || cmd.mem_write;
    assign vld_wdata = !cmd.clr_step;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg     <= in_op;
            player_reg <= in_player;
            key_reg    <= in_key;
            depth_reg  <= in_depth;
            score_reg  <= in_score;
        end
    end

    // A one-table sweep stops at the table's last slot, a full sweep at the last slot overall.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (cmd.capture) begin
            cnt_reg <= '0;
        end else if (cmd.clr_step) begin
            cnt_reg <= cnt_reg + {{AW{1'b0}}, 1'b1};
        end
    end

    assign stat.sweep_last = (&cnt_reg[AW-1:0]) && (cnt_reg[AW] || !cmd.sweep_all);
    assign stat.op         = op_reg;

    always_ff @(posedge aclk) begin
        if (vld_wen) begin
            valid_mem[vld_addr] <= vld_wdata;
        end
        if (cmd.mem_read) begin
            rd_valid_reg <= valid_mem[vld_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.mem_write) begin
            key_mem[slot_addr] <= key_reg;
        end
        if (cmd.mem_read) begin
            rd_key_reg <= key_mem[slot_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.mem_write) begin
            ds_mem[slot_addr] <= {depth_reg, score_reg};
        end
        if (cmd.mem_read) begin
            rd_ds_reg <= ds_mem[slot_addr];
        end
    end

    assign lookup_hit = (op_reg == tt_pkg::OP_LOOKUP) && rd_valid_reg
                        && (rd_key_reg == key_reg)
                        && (rd_ds_reg[tt_pkg::DS_W-1:tt_pkg::SCORE_W] >= depth_reg);

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            hit_reg       <= lookup_hit;
            hit_score_reg <= lookup_hit ? rd_ds_reg[tt_pkg::SCORE_W-1:0] : '0;
        end
    end

    assign out_hit   = hit_reg;
    assign out_score = hit_score_reg;

endmodule

// File: rtl/core/transposition_table_core.sv
// Top level of the transposition table core: two direct-mapped tables, one per player.
`timescale 1ns / 1ps
//
// An input item carries an operation and player in s_tuser and the key, depth and
// score in s_tdata. Each accepted item gives exactly one result item: the hit flag
// in m_tuser and the stored score (zero on a miss) in m_tdata.
// The block works on one item at a time. A lookup or an insert goes from acceptance
// to the result register by latching the item, then accessing the memory, then
// loading the result. s_tready returns the cycle after the result loads.
// A clear of one table walks its valid marks one slot a cycle; a clear of both
// tables walks the marks of both tables the same way.
// After reset the core sweeps all 2 * TABLE_ENTRIES valid marks to zero, with
// s_tready low, before it takes its first item.
// The result register holds its item while m_tready is low; the core can latch and
// process the next item meanwhile, and only waits before loading a new result.
// TABLE_ENTRIES must be a power of two of at least 2.
//
module transposition_table_core #(
    parameter int TABLE_ENTRIES = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [87:0] s_tdata,   // position_key[63:0], search_depth[71:64], eval_score[87:72]
    input  logic [2:0]  s_tuser,   // op[1:0], player[2]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // hit_score[15:0]
    output logic [0:0]  m_tuser    // hit[0]
);

    tt_pkg::tt_cmd_t  cmd;
    tt_pkg::tt_stat_t stat;
    logic             out_hit;

    tt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    tt_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_op     (s_tuser[1:0]),
        .in_player (s_tuser[2]),
        .in_key    (s_tdata[63:0]),
        .in_depth  (s_tdata[71:64]),
        .in_score  (s_tdata[87:72]),
        .cmd       (cmd),
        .stat      (stat),
        .out_hit   (out_hit),
        .out_score (m_tdata)
    );

    assign m_tuser[0] = out_hit;

    // A miss or a non-lookup item always carries a zero score.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == 16'd0))
        else $error("result without hit carries a nonzero score");

    // Only one item is in work at a time.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken again while an item is in work");

    // A result is never loaded in the cycle right after acceptance.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !$rose(m_tvalid))
        else $error("result appeared before the memory access finished");

    // After a lookup is accepted, the core holds input off until its result is loaded.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tuser[1:0] == tt_pkg::OP_LOOKUP)) |=> ##1 !s_tready)
        else $error("input taken before a lookup result was loaded");

endmodule

// File: test/transposition_table_core_tb.sv
// Self-checking testbench for transposition_table_core against a bench-side table model.
`timescale 1ns / 1ps

module transposition_table_core_tb;

    // A small table keeps clears short and makes slot collisions frequent.
    localparam int ENTRIES      = 64;
    localparam int IDX_W        = $clog2(ENTRIES);
    localparam int ITEM_COUNT   = 1900;
    localparam int HOLD_AT_ITEM = 700;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 20;
    localparam int MAX_REPORTS  = 10;
    localparam int TIMEOUT_NS   = 4_000_000;

    typedef struct {
        tt_pkg::op_t                op;
        logic                       player;
        logic [tt_pkg::KEY_W-1:0]   key;
        logic [tt_pkg::DEPTH_W-1:0] depth;
        logic [tt_pkg::SCORE_W-1:0] score;
    } tt_item_t;

    typedef struct {
        logic                       hit;
        logic [tt_pkg::SCORE_W-1:0] score;
    } tt_reply_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [87:0] s_tdata  = '0;   // position_key[63:0], search_depth[71:64], eval_score[87:72]
    logic [2:0]  s_tuser  = '0;   // op[1:0], player[2]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;         // hit_score[15:0]
    logic [0:0]  m_tuser;         // hit[0]

    // Table model, updated as items are accepted.
    logic [tt_pkg::KEY_W-1:0]   tbl_key   [2][ENTRIES];
    logic [tt_pkg::DEPTH_W-1:0] tbl_depth [2][ENTRIES];
    logic [tt_pkg::SCORE_W-1:0] tbl_score [2][ENTRIES];
    bit                         tbl_valid [2][ENTRIES];

    // Record of what the stimulus has written, so lookups only touch written slots.
    logic [tt_pkg::KEY_W-1:0]   gen_key     [2][ENTRIES];
    logic [tt_pkg::DEPTH_W-1:0] gen_depth   [2][ENTRIES];
    bit                         gen_written [2][ENTRIES];

    tt_item_t  queued_ops[$];
    tt_reply_t expected_replies[$];

    int        items_accepted = 0;
    int        total_items    = 0;
    int        error_count    = 0;

    tt_item_t  offered_op;
    int        burst_left = 0;
    int        gap_left   = 0;

    int        ready_mode    = 0;
    int        mode_cycles   = 0;
    int        pattern_pos   = 0;
    logic [7:0] ready_pattern = '0;
    logic      hold_off   = 1'b0;
    bit        hold_done  = 1'b0;
    int        hold_count = 0;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    transposition_table_core #(
        .TABLE_ENTRIES(ENTRIES)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    function automatic tt_reply_t apply_to_tables(input tt_item_t it);
        tt_reply_t r;
        int        slot;
        int        i;
        r.hit   = 1'b0;
        r.score = '0;
        slot    = int'(it.key[IDX_W-1:0]);
        case (it.op)
            tt_pkg::OP_LOOKUP: begin
                if (tbl_valid[it.player][slot] && tbl_key[it.player][slot] == it.key &&
                    tbl_depth[it.player][slot] >= it.depth) begin
                    r.hit   = 1'b1;
                    r.score = tbl_score[it.player][slot];
                end
            end
            tt_pkg::OP_INSERT: begin
                tbl_key[it.player][slot]   = it.key;
                tbl_depth[it.player][slot] = it.depth;
                tbl_score[it.player][slot] = it.score;
                tbl_valid[it.player][slot] = 1'b1;
            end
            tt_pkg::OP_CLEAR_ONE: begin
                for (i = 0; i < ENTRIES; i++) tbl_valid[it.player][i] = 1'b0;
            end
            default: begin
                for (i = 0; i < ENTRIES; i++) begin
                    tbl_valid[0][i] = 1'b0;
                    tbl_valid[1][i] = 1'b0;
                end
            end
        endcase
        return r;
    endfunction

    task automatic add_item(input tt_pkg::op_t op, input logic player,
                            input logic [tt_pkg::KEY_W-1:0] key,
                            input logic [tt_pkg::DEPTH_W-1:0] depth,
                            input logic [tt_pkg::SCORE_W-1:0] score);
        tt_item_t it;
        int       slot;
        it.op     = op;
        it.player = player;
        it.key    = key;
        it.depth  = depth;
        it.score  = score;
        slot      = int'(key[IDX_W-1:0]);
        if (op == tt_pkg::OP_INSERT) begin
            gen_written[player][slot] = 1'b1;
            gen_key[player][slot]     = key;
            gen_depth[player][slot]   = depth;
        end
        queued_ops.push_back(it);
    endtask

    function automatic int pick_written(input logic player);
        int start;
        int s;
        int n;
        start = $urandom_range(0, ENTRIES - 1);
        for (n = 0; n < ENTRIES; n++) begin
            s = (start + n) % ENTRIES;
            if (gen_written[player][s]) return s;
        end
        return -1;
    endfunction

    task automatic add_random_item();
        logic                       player;
        logic [tt_pkg::KEY_W-1:0]   key;
        logic [tt_pkg::DEPTH_W-1:0] depth;
        logic [tt_pkg::SCORE_W-1:0] score;
        int                         slot;
        int                         roll;
        int                         pick;
        int                         bit_pos;
        player = 1'($urandom_range(0, 1));
        key    = {$urandom, $urandom};
        depth  = 8'($urandom_range(0, 255));
        score  = 16'($urandom);
        roll   = $urandom_range(0, 99);
        slot   = pick_written(player);
        if (roll < 3) begin
            add_item(tt_pkg::OP_CLEAR_ONE, player, key, depth, score);
        end else if (roll < 5) begin
            add_item(tt_pkg::OP_CLEAR_ALL, player, key, depth, score);
        end else if (roll < 55 && slot >= 0) begin
            key  = gen_key[player][slot];
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                depth = 8'($urandom_range(0, gen_depth[player][slot]));
            end else if (pick < 72) begin
                // One deeper than stored: misses unless the stored depth is already 255.
                depth = (gen_depth[player][slot] == 8'hFF) ? 8'hFF
                                                          : gen_depth[player][slot] + 8'd1;
            end else if (pick < 90) begin
                // Same slot, different key above the index bits.
                bit_pos      = $urandom_range(IDX_W, tt_pkg::KEY_W - 1);
                key[bit_pos] = ~key[bit_pos];
            end
            add_item(tt_pkg::OP_LOOKUP, player, key, depth, score);
        end else begin
            if (slot >= 0 && $urandom_range(0, 3) == 0) key = gen_key[player][slot];
            if ($urandom_range(0, 9) == 0) depth = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            add_item(tt_pkg::OP_INSERT, player, key, depth, score);
        end
    endtask

    task automatic note_mismatch(input string what, input logic hit_exp,
                                 input logic [tt_pkg::SCORE_W-1:0] score_exp);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("%t: %s: expected hit=%0b score=%0d, got hit=%0b score=%0d", $realtime,
                     what, hit_exp, $signed(score_exp), m_tuser[0], $signed(m_tdata));
    endtask

    always @(posedge aclk) begin : drive_items
        tt_reply_t reply;
        tt_item_t  nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                reply = apply_to_tables(offered_op);
                expected_replies.push_back(reply);
                items_accepted <= items_accepted + 1;
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (queued_ops.size() != 0) begin
                    nxt        = queued_ops.pop_front();
                    offered_op = nxt;
                    s_tdata    <= {nxt.score, nxt.depth, nxt.key};
                    s_tuser    <= {nxt.player, nxt.op};
                    s_tvalid   <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 30);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin : pace_receiver
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (mode_cycles == 0) begin
                ready_mode    = $urandom_range(0, 3);
                ready_pattern = 8'($urandom);
                mode_cycles   = $urandom_range(20, 120);
                pattern_pos   = 0;
            end
            mode_cycles--;
            pattern_pos = (pattern_pos + 1) % 8;
            if (hold_off) begin
                m_tready <= 1'b0;
            end else begin
                case (ready_mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    2:       m_tready <= ready_pattern[pattern_pos[2:0]];
                    default: m_tready <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    // One long receiver stall partway through, so the core backs up and drops s_tready.
    always @(posedge aclk) begin : long_hold
        if (!aresetn) begin
            hold_off   <= 1'b0;
            hold_count <= 0;
            hold_done  <= 1'b0;
        end else if (hold_off) begin
            hold_count <= hold_count + 1;
            if (hold_count == HOLD_CYCLES - 1) begin
                hold_off  <= 1'b0;
                hold_done <= 1'b1;
            end
        end else if (!hold_done && items_accepted >= HOLD_AT_ITEM) begin
            hold_off <= 1'b1;
        end
    end

    always @(posedge aclk) begin : check_replies
        tt_reply_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_replies.size() == 0) begin
                note_mismatch("result item with nothing expected", 1'b0, '0);
            end else begin
                want = expected_replies.pop_front();
                if (m_tuser[0] !== want.hit || m_tdata !== want.score)
                    note_mismatch("result mismatch", want.hit, want.score);
            end
        end
    end

    initial begin : run_stimulus
        logic [tt_pkg::KEY_W-1:0] key_zero;
        logic [tt_pkg::KEY_W-1:0] key_ones;
        logic [tt_pkg::KEY_W-1:0] key_a;
        logic [tt_pkg::KEY_W-1:0] key_b;
        logic [tt_pkg::KEY_W-1:0] key_slot0;
        key_zero  = '0;
        key_ones  = '1;
        key_a     = 64'h0123_4567_89AB_CDEF;
        key_b     = 64'h8123_4567_89AB_CDEF;   // same slot as key_a
        key_slot0 = 64'h8000_0000_0000_0000;   // same slot as key_zero

        add_item(tt_pkg::OP_INSERT,    1'b0, key_zero,  8'd0,   16'h8000);
        add_item(tt_pkg::OP_LOOKUP,    1'b0, key_zero,  8'd0,   16'h0000);
        add_item(tt_pkg::OP_LOOKUP,    1'b0, key_slot0, 8'd0,   16'h0000);
        add_item(tt_pkg::OP_INSERT,    1'b1, key_ones,  8'd255, 16'h7FFF);
        add_item(tt_pkg::OP_LOOKUP,    1'b1, key_ones,  8'd255, 16'hFFFF);
        add_item(tt_pkg::OP_INSERT,    1'b0, key_a,     8'd10,  16'd5);
        add_item(tt_pkg::OP_LOOKUP,    1'b0, key_a,     8'd11,  16'h0000);
        add_item(tt_pkg::OP_LOOKUP,    1'b0, key_a,     8'd10,  16'h0000);
        add_item(tt_pkg::OP_INSERT,    1'b1, key_a,     8'd3,   16'hFFFF);
        add_item(tt_pkg::OP_LOOKUP,    1'b1, key_a,     8'd3,   16'h0000);
        // A clear must ignore its key, depth and score fields.
        add_item(tt_pkg::OP_CLEAR_ONE, 1'b0, key_ones,  8'd255, 16'hFFFF);
        add_item(tt_pkg::OP_LOOKUP,    1'b0, key_a,     8'd0,   16'h0000);
        add_item(tt_pkg::OP_LOOKUP,    1'b1, key_a,     8'd0,   16'h0000);
        add_item(tt_pkg::OP_INSERT,    1'b0, key_a,     8'd7,   16'd100);
        add_item(tt_pkg::OP_LOOKUP,    1'b0, key_a,     8'd7,   16'h0000);
        add_item(tt_pkg::OP_INSERT,    1'b0, key_b,     8'd200, 16'd1234);
        add_item(tt_pkg::OP_LOOKUP,    1'b0, key_a,     8'd0,   16'h0000);
        add_item(tt_pkg::OP_LOOKUP,    1'b0, key_b,     8'd200, 16'h0000);
        add_item(tt_pkg::OP_CLEAR_ALL, 1'b1, key_zero,  8'd0,   16'h0000);
        add_item(tt_pkg::OP_LOOKUP,    1'b0, key_b,     8'd0,   16'h0000);
        add_item(tt_pkg::OP_LOOKUP,    1'b1, key_ones,  8'd0,   16'h0000);
        add_item(tt_pkg::OP_CLEAR_ONE, 1'b1, key_zero,  8'd0,   16'h0000);

        repeat (ITEM_COUNT - queued_ops.size()) add_random_item();
        total_items = queued_ops.size();

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        while (items_accepted != total_items) @(posedge aclk);
        while (expected_replies.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        error_count += expected_replies.size();

        if (error_count == 0) begin
            $display("transposition_table_core_tb: done, clean");
        end else begin
            $display("transposition_table_core_tb: done, errors");
        end
        $finish;
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("transposition_table_core_tb: done, errors");
        $finish;
    end

endmodule
